FILE: hdl/afd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the raw-to-milli-g conversion for the fall detector.
// No dependencies; used by afd_axis_filter and accel_fall_detector.

package afd_pkg;

    // Moving-average window; the average is taken by shift, so keep it a power of two.
    localparam int WINDOW    = 8;
    localparam int WIN_IDX_W = $clog2(WINDOW);

    localparam int RAW_W     = 16;
    localparam int RAW_PER_G = 16384;
    localparam int RAW_SHIFT = $clog2(RAW_PER_G);
    localparam int PROD_W    = 26;
    localparam logic signed [PROD_W-1:0] MG_SCALE = 26'sd1000;

    localparam int MG_W   = 12;
    localparam int SUM_W  = MG_W + WIN_IDX_W;
    localparam int ABS_W  = 11;
    localparam int DIFF_W = 12;
    localparam int MAG_W  = 13;
    localparam int TILT_W = 14;
    localparam int CNT_W  = 10;
    localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_IMPACT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 3'd3;

    localparam logic [MAG_W-1:0]  IMPACT_RST = 13'd5400;
    localparam logic [TILT_W-1:0] TILT_RST   = 14'd700;
    localparam logic [CNT_W-1:0]  SETTLE_RST = 10'd40;
    localparam logic [CNT_W-1:0]  HOLD_RST   = 10'd75;

    localparam logic [1:0] MODE_SETTLE  = 2'd0;
    localparam logic [1:0] MODE_MONITOR = 2'd1;
    localparam logic [1:0] MODE_EVENT   = 2'd2;

    typedef struct packed {
        logic signed [RAW_W-1:0] accel_x_raw;
        logic signed [RAW_W-1:0] accel_y_raw;
        logic signed [RAW_W-1:0] accel_z_raw;
    } t_in;

    typedef struct packed {
        logic signed [MG_W-1:0] filt_x;
        logic signed [MG_W-1:0] filt_y;
        logic signed [MG_W-1:0] filt_z;
        logic [MAG_W-1:0]       magnitude;
        logic [TILT_W-1:0]      tilt_change;
        logic [1:0]             mode;
        logic                   event_start;
    } t_out;

    // Per-axis results handed from the filter to the top level.
    typedef struct packed {
        logic signed [MG_W-1:0] filt;
        logic [ABS_W-1:0]       mag_abs;
        logic [DIFF_W-1:0]      diff_abs;
    } t_axis_res;

    // raw * 1000 / 16384, truncated toward zero.
    function automatic logic signed [MG_W-1:0] to_mg(input logic signed [RAW_W-1:0] raw);
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] biased;
        logic signed [PROD_W-1:0] shifted;
        prod = PROD_W'(raw) * MG_SCALE;
        biased = prod + (prod[PROD_W-1] ? PROD_W'(RAW_PER_G - 1) : PROD_W'(0));
        shifted = biased >>> RAW_SHIFT;
        return shifted[MG_W-1:0];
    endfunction

endpackage

FILE: hdl/afd_axis_filter.sv
`timescale 1ns / 1ps
// One axis of the fall detector: moving-average ring, running sum and previous sample.
// Depends on afd_pkg.

module afd_axis_filter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic signed [afd_pkg::MG_W-1:0]  i_mg,
    output afd_pkg::t_axis_res               o_res
);

    logic signed [afd_pkg::MG_W-1:0]  r_ring [afd_pkg::WINDOW];
    logic signed [afd_pkg::SUM_W-1:0] r_sum;
    logic [afd_pkg::WIN_IDX_W-1:0]    r_idx;
    logic signed [afd_pkg::MG_W-1:0]  r_prev;

    logic signed [afd_pkg::SUM_W-1:0] n_sum;
    logic signed [afd_pkg::SUM_W-1:0] biased;
    logic signed [afd_pkg::SUM_W-1:0] shifted;
    logic [afd_pkg::WIN_IDX_W-1:0]    n_idx;
    logic signed [afd_pkg::MG_W-1:0]  n_filt;
    logic signed [afd_pkg::MG_W-1:0]  neg_filt;
    logic signed [afd_pkg::MG_W:0]    diff;
    logic signed [afd_pkg::MG_W:0]    neg_diff;

    always_comb begin
        n_sum = r_sum - afd_pkg::SUM_W'(r_ring[r_idx]) + afd_pkg::SUM_W'(i_mg);
        // bias negative sums so the shift truncates toward zero
        biased = n_sum + (n_sum[afd_pkg::SUM_W-1] ? afd_pkg::SUM_W'(afd_pkg::WINDOW - 1)
                                                  : afd_pkg::SUM_W'(0));
        shifted = biased >>> afd_pkg::WIN_IDX_W;
        n_filt = shifted[afd_pkg::MG_W-1:0];
        neg_filt = -n_filt;
        diff = {n_filt[afd_pkg::MG_W-1], n_filt} - {r_prev[afd_pkg::MG_W-1], r_prev};
        neg_diff = -diff;
        n_idx = (r_idx == afd_pkg::WIN_IDX_W'(afd_pkg::WINDOW - 1)) ? '0 : r_idx + 1'b1;

        o_res.filt = n_filt;
        o_res.mag_abs = n_filt[afd_pkg::MG_W-1] ? neg_filt[afd_pkg::ABS_W-1:0]
                                                : n_filt[afd_pkg::ABS_W-1:0];
        o_res.diff_abs = diff[afd_pkg::MG_W] ? neg_diff[afd_pkg::DIFF_W-1:0]
                                             : diff[afd_pkg::DIFF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < afd_pkg::WINDOW; i++) begin
                r_ring[i] <= '0;
            end
            r_sum  <= '0;
            r_idx  <= '0;
            r_prev <= '0;
        end else if (i_en) begin
            r_ring[r_idx] <= i_mg;
            r_sum  <= n_sum;
            r_idx  <= n_idx;
            r_prev <= n_filt;
        end
    end

endmodule

FILE: hdl/accel_fall_detector.sv
`timescale 1ns / 1ps
// Top level of the fall detector: input stage, three axis filters, mode machine, result register.
// Depends on afd_pkg and afd_axis_filter.

// Accepts one three-axis sample per cycle and returns one result item per sample, passing
// through two registers. The first register holds the samples converted to milli-g; the second is
// the result register, loaded as the 8-entry moving averages, magnitude, tilt change and mode
// are updated. Throughput is one item per cycle, set by that two-register pipeline; input ready
// drops only while both registers are full and the result is not taken. Configuration writes
// take effect at once and are meant to happen while the block is idle.

module accel_fall_detector (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  afd_pkg::t_in                         i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output afd_pkg::t_out                        o_out,
    input  logic                                 i_cfg_we,
    input  logic [afd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [afd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    typedef enum logic [2:0] {
        S_SETTLE  = 3'b001,
        S_MONITOR = 3'b010,
        S_EVENT   = 3'b100
    } t_mode;

    logic [afd_pkg::MAG_W-1:0]  r_impact_thr;
    logic [afd_pkg::TILT_W-1:0] r_tilt_thr;
    logic [afd_pkg::CNT_W-1:0]  r_settle_samples;
    logic [afd_pkg::CNT_W-1:0]  r_hold_samples;

    logic                             r_a_valid;
    logic signed [afd_pkg::MG_W-1:0]  r_a_x;
    logic signed [afd_pkg::MG_W-1:0]  r_a_y;
    logic signed [afd_pkg::MG_W-1:0]  r_a_z;
    logic                             r_b_valid;
    afd_pkg::t_out                    r_out;

    t_mode                      r_mode;
    t_mode                      n_mode;
    logic [afd_pkg::CNT_W-1:0]  r_settle_cnt;
    logic [afd_pkg::CNT_W-1:0]  n_settle_cnt;
    logic [afd_pkg::CNT_W-1:0]  r_hold_cnt;
    logic [afd_pkg::CNT_W-1:0]  n_hold_cnt;
    logic                       n_start;
    logic [1:0]                 n_mode_code;

    logic                       adv_b;
    logic                       in_fire;
    afd_pkg::t_axis_res         res_x;
    afd_pkg::t_axis_res         res_y;
    afd_pkg::t_axis_res         res_z;
    logic [afd_pkg::MAG_W-1:0]  mag;
    logic [afd_pkg::TILT_W-1:0] tilt;

    assign adv_b       = r_a_valid && (!r_b_valid || i_out_ready);
    assign o_in_ready  = !r_a_valid || adv_b;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_b_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_impact_thr     <= afd_pkg::IMPACT_RST;
            r_tilt_thr       <= afd_pkg::TILT_RST;
            r_settle_samples <= afd_pkg::SETTLE_RST;
            r_hold_samples   <= afd_pkg::HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                afd_pkg::CFG_IMPACT: r_impact_thr     <= i_cfg_data[afd_pkg::MAG_W-1:0];
                afd_pkg::CFG_TILT:   r_tilt_thr       <= i_cfg_data[afd_pkg::TILT_W-1:0];
                afd_pkg::CFG_SETTLE: r_settle_samples <= i_cfg_data[afd_pkg::CNT_W-1:0];
                afd_pkg::CFG_HOLD:   r_hold_samples   <= i_cfg_data[afd_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input stage: convert to milli-g on the way in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_x <= afd_pkg::to_mg(i_in.accel_x_raw);
            r_a_y <= afd_pkg::to_mg(i_in.accel_y_raw);
            r_a_z <= afd_pkg::to_mg(i_in.accel_z_raw);
        end
    end

    afd_axis_filter u_filt_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv_b),
        .i_mg    (r_a_x),
        .o_res   (res_x)
    );

    afd_axis_filter u_filt_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv_b),
        .i_mg    (r_a_y),
        .o_res   (res_y)
    );

    afd_axis_filter u_filt_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv_b),
        .i_mg    (r_a_z),
        .o_res   (res_z)
    );

    always_comb begin
        mag  = afd_pkg::MAG_W'(res_x.mag_abs) + afd_pkg::MAG_W'(res_y.mag_abs)
             + afd_pkg::MAG_W'(res_z.mag_abs);
        tilt = afd_pkg::TILT_W'(res_x.diff_abs) + afd_pkg::TILT_W'(res_y.diff_abs)
             + afd_pkg::TILT_W'(res_z.diff_abs);

        n_mode       = r_mode;
        n_settle_cnt = r_settle_cnt;
        n_hold_cnt   = r_hold_cnt;
        n_start      = 1'b0;
        case (r_mode)
            S_SETTLE: begin
                if (r_settle_cnt < afd_pkg::CNT_MAX) begin
                    n_settle_cnt = r_settle_cnt + 1'b1;
                end
                if (n_settle_cnt >= r_settle_samples) begin
                    n_mode = S_MONITOR;
                end
            end
            S_MONITOR: begin
                if (mag >= r_impact_thr && tilt >= r_tilt_thr) begin
                    n_mode     = S_EVENT;
                    n_hold_cnt = '0;
                    n_start    = 1'b1;
                end
            end
            S_EVENT: begin
                if (r_hold_cnt < afd_pkg::CNT_MAX) begin
                    n_hold_cnt = r_hold_cnt + 1'b1;
                end
                if (n_hold_cnt >= r_hold_samples) begin
                    n_mode = S_MONITOR;
                end
            end
            default: begin
                n_mode       = S_SETTLE;
                n_settle_cnt = '0;
            end
        endcase

        case (n_mode)
            S_MONITOR: n_mode_code = afd_pkg::MODE_MONITOR;
            S_EVENT:   n_mode_code = afd_pkg::MODE_EVENT;
            default:   n_mode_code = afd_pkg::MODE_SETTLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= S_SETTLE;
            r_settle_cnt <= '0;
            r_hold_cnt   <= '0;
            r_b_valid    <= 1'b0;
        end else begin
            if (adv_b) begin
                r_mode       <= n_mode;
                r_settle_cnt <= n_settle_cnt;
                r_hold_cnt   <= n_hold_cnt;
                r_b_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_b) begin
            r_out.filt_x      <= res_x.filt;
            r_out.filt_y      <= res_y.filt;
            r_out.filt_z      <= res_z.filt;
            r_out.magnitude   <= mag;
            r_out.tilt_change <= tilt;
            r_out.mode        <= n_mode_code;
            r_out.event_start <= n_start;
        end
    end

    a_start_in_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.event_start) |-> (o_out.mode == afd_pkg::MODE_EVENT))
        else $error("event_start reported outside event mode");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_a_valid && r_b_valid && !i_out_ready))
        else $error("input stalled with room in the pipeline");

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_b |=> o_out_valid)
        else $error("advanced item missing from result register");

endmodule
